/* rtl/core/wfc_pkg.sv */
// ----------------------------------------------------------------------------
// wfc_pkg
// Shared types and constants of the waveform frequency classifier.
// ----------------------------------------------------------------------------
package wfc_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int TIME_W     = 32;
  localparam int TALLY_W    = 8;
  localparam int SCALE_W    = 16;
  localparam int FLAT_MIN_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int S_DATA_W   = 48;
  localparam int M_DATA_W   = 72;
  localparam int M_USER_W   = 3;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
  localparam logic [TALLY_W-1:0]  TALLY_MAX  = '1;

  // Register reset values
  localparam logic [SAMPLE_W-1:0]   SMALL_LIMIT_RST = SAMPLE_W'(5);
  localparam logic [FLAT_MIN_W-1:0] FLAT_MIN_RST    = FLAT_MIN_W'(53);
  localparam logic [SCALE_W-1:0]    TRI_SCALE_RST   = SCALE_W'(3000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMALL_LIMIT = 2'd0,
    REG_FLAT_MIN    = 2'd1,
    REG_TRI_SCALE   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLASS_SQUARE   = 2'd0,
    CLASS_TRIANGLE = 2'd1,
    CLASS_SINE     = 2'd2
  } wave_class_t;

  // End-of-capture figures handed from the update stage to the classify stage
  typedef struct packed {
    logic [SAMPLE_W-1:0] peak_high;
    logic [SAMPLE_W-1:0] peak_low;
    logic [TIME_W-1:0]   period_ms;
    logic                period_known;
    logic [TALLY_W-1:0]  small_count;
    logic [TALLY_W-1:0]  flat_count;
  } capture_sum_t;

endpackage

/* rtl/core/waveform_frequency_classifier_core.sv */
// ----------------------------------------------------------------------------
// waveform_frequency_classifier_core
// Classifies one capture of ADC samples as square, triangular or sine.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one sample word per handshake; s_tlast marks the final sample
//   of a capture. Every sample updates the running peaks, midpoint crossing
//   detector and second-difference tallies. The final sample produces one
//   word on m_*: class and period flag on m_tuser, peaks, period and tallies
//   on m_tdata. Non-final samples produce nothing.
//   cfg_* writes the three registers (index 0 small limit, 1 flat minimum,
//   2 triangle scale); cfg_ready is always high. The user writes only while idle; the block does not enforce it.
// Timing:
//   Three register stages: input register, capture update, classify/output.
//   The final sample passes the input register and the summary register before m_tvalid rises.
//   One sample is accepted every cycle while the output side keeps up.
// Reset:
//   rst (synchronous) empties the pipeline, clears the capture state, the
//   period and the crossing arm, and loads register defaults.
// Stall:
//   While m_tready is low the output word holds; the pipeline then fills
//   and s_tready drops once all stages are occupied.
// ----------------------------------------------------------------------------
module waveform_frequency_classifier_core (
  input  logic                           clk,
  input  logic                           rst,
  // slave stream: [9:0] sample, [41:10] time_ms, rest zero
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [wfc_pkg::S_DATA_W-1:0]   s_tdata,
  input  logic                           s_tlast,
  // master stream: [9:0] peak_high, [19:10] peak_low, [51:20] period_ms,
  // [59:52] small_count, [67:60] flat_count, rest zero
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [wfc_pkg::M_DATA_W-1:0]   m_tdata,
  // master user: [1:0] wave_class, [2] period_known
  output logic [wfc_pkg::M_USER_W-1:0]   m_tuser,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wfc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wfc_pkg::*;

  // configuration registers
  logic [SAMPLE_W-1:0]   small_limit;
  logic [FLAT_MIN_W-1:0] flat_min;
  logic [SCALE_W-1:0]    tri_scale;

  // input register
  logic                in_valid;
  logic [SAMPLE_W-1:0] in_sample;
  logic [TIME_W-1:0]   in_time;
  logic                in_last;

  // capture state
  logic [SAMPLE_W-1:0] run_high;
  logic [SAMPLE_W-1:0] run_low;
  logic [SAMPLE_W-1:0] prev_one;
  logic [SAMPLE_W-1:0] prev_two;
  logic [1:0]          history_fill;
  logic [TALLY_W-1:0]  small_tally;
  logic [TALLY_W-1:0]  flat_tally;
  logic                above_mid;
  logic [TIME_W-1:0]   cross_time;
  logic                cross_time_valid;
  logic [TIME_W-1:0]   period_reg;
  logic                period_valid;

  // summary stage
  logic         sum_valid;
  capture_sum_t sum_reg;

  // handshakes
  logic out_free;
  logic sum_ready;
  logic upd_go;
  logic sum_go;

  assign out_free  = !m_tvalid || m_tready;
  assign sum_ready = !sum_valid || out_free;
  assign upd_go    = in_valid && sum_ready;
  assign sum_go    = sum_valid && out_free;
  assign s_tready  = !in_valid || sum_ready;
  assign cfg_ready = 1'b1;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      small_limit <= SMALL_LIMIT_RST;
      flat_min    <= FLAT_MIN_RST;
      tri_scale   <= TRI_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SMALL_LIMIT: small_limit <= cfg_data[SAMPLE_W-1:0];
        REG_FLAT_MIN:    flat_min    <= cfg_data[FLAT_MIN_W-1:0];
        REG_TRI_SCALE:   tri_scale   <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- input register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample <= s_tdata[SAMPLE_W-1:0];
      in_time   <= s_tdata[SAMPLE_W +: TIME_W];
      in_last   <= s_tlast;
    end
  end

  // ---------------- capture update ----------------
  logic [SAMPLE_W-1:0]       run_high_next;
  logic [SAMPLE_W-1:0]       run_low_next;
  logic [SAMPLE_W:0]         twice;
  logic [SAMPLE_W:0]         mid_sum;
  logic                      rise;
  logic                      fall;
  logic                      above_mid_next;
  logic [TIME_W-1:0]         period_next;
  logic                      period_valid_next;
  logic signed [SAMPLE_W+1:0] diff2;
  logic [SAMPLE_W:0]         diff_mag;
  logic                      hist_full;
  logic [TALLY_W-1:0]        small_next;
  logic [TALLY_W-1:0]        flat_next;

  always_comb begin
    run_high_next = (in_sample > run_high) ? in_sample : run_high;
    run_low_next  = (in_sample < run_low) ? in_sample : run_low;
    twice         = {in_sample, 1'b0};
    mid_sum       = {1'b0, run_high_next} + {1'b0, run_low_next};
    rise          = !above_mid && (twice > mid_sum);
    fall          = twice < mid_sum;

    above_mid_next = above_mid;
    if (rise) above_mid_next = 1'b1;
    if (fall) above_mid_next = 1'b0;

    period_next       = period_reg;
    period_valid_next = period_valid;
    if (rise && cross_time_valid) begin
      period_next       = in_time - cross_time;
      period_valid_next = 1'b1;
    end

    diff2 = $signed({2'b00, in_sample}) - $signed({1'b0, prev_one, 1'b0})
          + $signed({2'b00, prev_two});
    diff_mag  = diff2[SAMPLE_W+1] ? (SAMPLE_W+1)'(0) - diff2[SAMPLE_W:0]
                                  : diff2[SAMPLE_W:0];
    hist_full = history_fill[1];

    small_next = small_tally;
    flat_next  = flat_tally;
    if (hist_full) begin
      if ((diff_mag < {1'b0, small_limit}) && (small_tally != TALLY_MAX)) begin
        small_next = small_tally + TALLY_W'(1);
      end
      if ((diff_mag == '0) && (flat_tally != TALLY_MAX)) begin
        flat_next = flat_tally + TALLY_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_high         <= '0;
      run_low          <= SAMPLE_MAX;
      prev_one         <= '0;
      prev_two         <= '0;
      history_fill     <= '0;
      small_tally      <= '0;
      flat_tally       <= '0;
      above_mid        <= 1'b0;
      cross_time       <= '0;
      cross_time_valid <= 1'b0;
      period_reg       <= '0;
      period_valid     <= 1'b0;
    end else if (upd_go) begin
      above_mid    <= above_mid_next;
      period_reg   <= period_next;
      period_valid <= period_valid_next;
      if (in_last) begin
        // end of capture: drop the per-capture state
        run_high         <= '0;
        run_low          <= SAMPLE_MAX;
        prev_one         <= '0;
        prev_two         <= '0;
        history_fill     <= '0;
        small_tally      <= '0;
        flat_tally       <= '0;
        cross_time       <= '0;
        cross_time_valid <= 1'b0;
      end else begin
        run_high     <= run_high_next;
        run_low      <= run_low_next;
        prev_one     <= in_sample;
        prev_two     <= prev_one;
        history_fill <= hist_full ? history_fill : history_fill + 2'd1;
        small_tally  <= small_next;
        flat_tally   <= flat_next;
        if (rise) begin
          cross_time       <= in_time;
          cross_time_valid <= 1'b1;
        end
      end
    end
  end

  // ---------------- capture summary ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (sum_ready) begin
      sum_valid <= upd_go && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go && in_last) begin
      sum_reg.peak_high    <= run_high_next;
      sum_reg.peak_low     <= run_low_next;
      sum_reg.period_ms    <= period_next;
      sum_reg.period_known <= period_valid_next;
      sum_reg.small_count  <= small_next;
      sum_reg.flat_count   <= flat_next;
    end
  end

  // ---------------- classify ----------------
  logic [TALLY_W:0]         small_plus;
  logic [TALLY_W+SCALE_W:0] tri_product;
  logic                     period_long;
  wave_class_t              class_next;

  always_comb begin
    small_plus  = {1'b0, sum_reg.small_count} + (TALLY_W+1)'(1);
    tri_product = small_plus * sum_reg.period_ms[SCALE_W-1:0];
    // a period beyond the scale width always exceeds it, small_plus >= 1
    period_long = sum_reg.period_ms[TIME_W-1:SCALE_W] != '0;
    if (sum_reg.flat_count >= flat_min) begin
      class_next = CLASS_SQUARE;
    end else if (!sum_reg.period_known || period_long ||
                 (tri_product > {{(TALLY_W+1){1'b0}}, tri_scale})) begin
      class_next = CLASS_TRIANGLE;
    end else begin
      class_next = CLASS_SINE;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= sum_go;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_go) begin
      m_tuser <= {sum_reg.period_known, class_next};
      m_tdata <= {4'b0000, sum_reg.flat_count, sum_reg.small_count,
                  sum_reg.period_ms, sum_reg.peak_low, sum_reg.peak_high};
    end
  end

endmodule

/* rtl/core/wfc_checker.sv */
// ----------------------------------------------------------------------------
// wfc_checker
// Port-level checks on the waveform frequency classifier, bound to the core.
// ----------------------------------------------------------------------------
module wfc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [wfc_pkg::M_DATA_W-1:0] m_tdata,
  input logic [wfc_pkg::M_USER_W-1:0] m_tuser
);
  import wfc_pkg::*;

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // no period measured means a zero period field
  a_period_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[2] |-> m_tdata[51:20] == '0)
    else $error("period reported without a measurement");

  // every capture holds a sample, so the peaks are ordered
  a_peaks_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[9:0] >= m_tdata[19:10])
    else $error("peak high below peak low");

  // class stays within its codes; only a sine needs a known period
  a_class_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[1:0] == CLASS_SQUARE) || (m_tuser[1:0] == CLASS_TRIANGLE) ||
                 ((m_tuser[1:0] == CLASS_SINE) && m_tuser[2]))
    else $error("bad class code");

endmodule

bind waveform_frequency_classifier_core wfc_checker u_wfc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
